// ===== sv/qrrs_pkg.sv =====
// qrrs_pkg: sizes, request types and GF(256) helpers for the QR parity encoder
// holds the generator coefficient table for every parity count
// no dependencies
package qrrs_pkg;

  localparam int MAX_ECC   = 30;
  localparam int CNT_W     = $clog2(MAX_ECC + 1);
  localparam int ECC_RESET = 7;
  localparam int ECC_RESET_EFF = (ECC_RESET > MAX_ECC) ? MAX_ECC : ECC_RESET;
  localparam logic [8:0] GF_POLY = 9'h11D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_data;
  } in_req_t;

  typedef struct packed {
    logic [7:0] ecc_byte;
    logic       ecc_last;
  } out_req_t;

  // one accepted data request as seen by the remainder logic
  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] data;
  } lfsr_ctl_t;

  typedef logic [MAX_ECC-1:0][7:0] byte_vec_t;
  typedef byte_vec_t [MAX_ECC:0] gen_tab_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] p;
    x = {1'b0, a};
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ x[7:0];
      end
      x = x << 1;
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return p;
  endfunction

  // row n holds g(x) = prod (x - a^i), i = 0..n-1, below the leading 1, highest first
  function automatic gen_tab_t build_gen_tab();
    gen_tab_t            tab;
    logic [MAX_ECC:0][7:0] poly;
    logic [7:0]          root;
    tab = '0;
    for (int n = 1; n <= MAX_ECC; n++) begin
      poly    = '0;
      poly[0] = 8'h01;
      root    = 8'h01;
      for (int d = 0; d < n; d++) begin
        poly[d+1] = gf_mul(poly[d], root);
        for (int k = d; k >= 1; k--) begin
          poly[k] = poly[k] ^ gf_mul(poly[k-1], root);
        end
        root = gf_mul(root, 8'h02);
      end
      for (int k = 0; k < n; k++) begin
        tab[n][k] = poly[k+1];
      end
    end
    return tab;
  endfunction

  localparam gen_tab_t GEN_TAB = build_gen_tab();

endpackage

// ===== sv/qrrs_lfsr.sv =====
// qrrs_lfsr: parity count, generator coefficients and the GF(256) remainder register
// one data byte per step through a parallel division LFSR
// depends on qrrs_pkg
module qrrs_lfsr (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_value,
  input  qrrs_pkg::lfsr_ctl_t ctl,
  output qrrs_pkg::byte_vec_t rem_nxt,
  output logic [qrrs_pkg::CNT_W-1:0] eff_count
);
  import qrrs_pkg::*;

  logic [CNT_W-1:0] eff_r;
  logic [CNT_W-1:0] eff_nxt;
  byte_vec_t        gen_r;
  byte_vec_t        rem_r;
  byte_vec_t        rem_up;
  logic [7:0]       fb;

  // zero counts as one, saturate at the table size
  always_comb begin
    if (cfg_value == 5'd0) begin
      eff_nxt = CNT_W'(1);
    end else if (int'(cfg_value) > MAX_ECC) begin
      eff_nxt = CNT_W'(MAX_ECC);
    end else begin
      eff_nxt = CNT_W'(int'(cfg_value));
    end
  end

  // unused upper remainder bytes stay zero, so one uniform shift covers any count
  assign fb     = ctl.data ^ rem_r[0];
  assign rem_up = {8'h00, rem_r[MAX_ECC-1:1]};

  always_comb begin
    for (int i = 0; i < MAX_ECC; i++) begin
      rem_nxt[i] = rem_up[i] ^ gf_mul(gen_r[i], fb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r <= CNT_W'(ECC_RESET_EFF);
      gen_r <= GEN_TAB[ECC_RESET_EFF];
      rem_r <= '0;
    end else if (cfg_we) begin
      eff_r <= eff_nxt;
      gen_r <= GEN_TAB[eff_nxt];
      rem_r <= '0;
    end else if (ctl.step) begin
      rem_r <= ctl.last ? '0 : rem_nxt;
    end
  end

  assign eff_count = eff_r;

endmodule

// ===== sv/qr_reed_solomon_ecc_encoder.sv =====
// qr_reed_solomon_ecc_encoder: systematic RS(GF(256)) parity generator for QR data blocks
// remainder logic in qrrs_lfsr, parity run drained from a shift register here
// depends on qrrs_pkg, qrrs_lfsr
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_stall  | in_data   (data_byte, last_data)
//  out     | output    | out_valid / out_stall| out_data  (ecc_byte, ecc_last)
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (ecc_count, 5 bits)
//
// data bytes that are not last are taken every cycle, also while a
// parity run drains, since the remainder and the drain register are separate
// parity bytes leave the drain register at one per cycle while out_stall is low, so a
// last-byte request waits until the previous run is down to its final byte being taken
// synchronous active-low reset: count 7, remainder clear, no run pending
// out_stall only holds the drain register and, for last bytes, the input
module qr_reed_solomon_ecc_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qrrs_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qrrs_pkg::out_req_t out_data,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data
);
  import qrrs_pkg::*;

  lfsr_ctl_t        ctl;
  byte_vec_t        rem_nxt;
  logic [CNT_W-1:0] eff_count;

  // parity run waiting to go out, lowest index leaves first
  byte_vec_t        drain_r;
  logic [CNT_W-1:0] cnt_r;

  logic in_take;
  logic out_take;
  logic room;

  assign out_valid = (cnt_r != '0);
  assign out_take  = out_valid && !out_stall;

  // drain register free now, or freeing on this edge
  assign room = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && !out_stall);

  // only a last byte needs the drain register
  assign in_stall = in_data.last_data && !room;
  assign in_take  = in_valid && !in_stall;

  assign ctl.step = in_take;
  assign ctl.last = in_data.last_data;
  assign ctl.data = in_data.data_byte;

  qrrs_lfsr u_lfsr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr_en),
    .cfg_value (cfg_wr_data),
    .ctl       (ctl),
    .rem_nxt   (rem_nxt),
    .eff_count (eff_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_take && in_data.last_data) begin
      // finished block: its full remainder becomes the next run
      cnt_r <= eff_count;
    end else if (out_take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_take && in_data.last_data) begin
      drain_r <= rem_nxt;
    end else if (out_take) begin
      drain_r <= {8'h00, drain_r[MAX_ECC-1:1]};
    end
  end

  assign out_data.ecc_byte = drain_r[0];
  assign out_data.ecc_last = (cnt_r == CNT_W'(1));

endmodule

// ===== tb/qrrs_parity_checker.sv =====
`timescale 1ns / 1ps
// qrrs_parity_checker: watches the data, parity and count ports of the QR parity encoder
// keeps its own GF(256) remainder model and checks every parity request in order
// depends on qrrs_pkg
module qrrs_parity_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  qrrs_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  qrrs_pkg::out_req_t out_data,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  output int                 mismatch_count,
  output int                 parity_left
);
  import qrrs_pkg::*;

  logic [7:0] rem_r [MAX_ECC];
  logic [7:0] gen_r [MAX_ECC];
  int         n_eff;
  out_req_t   parity_q [$];
  int         fail_n;

  // shift-and-add product, reducing by the field polynomial on each doubling
  function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] term;
    logic [7:0] prod;
    term = a;
    prod = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        prod = prod ^ term;
      end
      term = {term[6:0], 1'b0} ^ (term[7] ? GF_POLY[7:0] : 8'h00);
    end
    return prod;
  endfunction

  // new parity count: rebuild g(x) and start a fresh block
  task automatic load_generator(input logic [4:0] count);
    logic [7:0] poly [MAX_ECC+1];
    logic [7:0] root;
    if (count == 5'd0) begin
      n_eff = 1;
    end else if (int'(count) > MAX_ECC) begin
      n_eff = MAX_ECC;
    end else begin
      n_eff = int'(count);
    end
    for (int k = 0; k <= MAX_ECC; k++) begin
      poly[k] = 8'h00;
    end
    poly[0] = 8'h01;
    root    = 8'h01;
    for (int d = 0; d < n_eff; d++) begin
      poly[d+1] = gf256_mul(poly[d], root);
      for (int k = d; k >= 1; k--) begin
        poly[k] = poly[k] ^ gf256_mul(poly[k-1], root);
      end
      root = gf256_mul(root, 8'h02);
    end
    for (int k = 0; k < MAX_ECC; k++) begin
      gen_r[k] = (k < n_eff) ? poly[k+1] : 8'h00;
      rem_r[k] = 8'h00;
    end
  endtask

  // one data byte through the divider; a last byte queues the whole parity run
  task automatic absorb_byte(input in_req_t req);
    logic [7:0] fb;
    out_req_t   res;
    fb = req.data_byte ^ rem_r[0];
    for (int i = 0; i < n_eff - 1; i++) begin
      rem_r[i] = rem_r[i+1] ^ gf256_mul(gen_r[i], fb);
    end
    rem_r[n_eff-1] = gf256_mul(gen_r[n_eff-1], fb);
    if (req.last_data) begin
      for (int i = 0; i < n_eff; i++) begin
        res.ecc_byte = rem_r[i];
        res.ecc_last = (i == n_eff - 1);
        parity_q = {parity_q, res};
      end
      for (int k = 0; k < MAX_ECC; k++) begin
        rem_r[k] = 8'h00;
      end
    end
  endtask

  task automatic check_parity(input out_req_t got);
    out_req_t want;
    if (parity_q.size() == 0) begin
      $display("%0t unexpected parity request: expected none actual byte %02h last %0b",
               $time, got.ecc_byte, got.ecc_last);
      fail_n++;
    end else begin
      want = parity_q.pop_front();
      if (got.ecc_byte !== want.ecc_byte) begin
        $display("%0t ecc_byte mismatch: expected %02h actual %02h",
                 $time, want.ecc_byte, got.ecc_byte);
        fail_n++;
      end
      if (got.ecc_last !== want.ecc_last) begin
        $display("%0t ecc_last mismatch: expected %0b actual %0b",
                 $time, want.ecc_last, got.ecc_last);
        fail_n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      load_generator(5'(ECC_RESET));
      parity_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_parity(out_data);
      end
      if (cfg_wr_en) begin
        load_generator(cfg_wr_data);
      end
      if (in_valid && !in_stall) begin
        absorb_byte(in_data);
      end
    end
    mismatch_count <= fail_n;
    parity_left    <= parity_q.size();
  end

endmodule

// ===== tb/qr_reed_solomon_ecc_encoder_test.sv =====
`timescale 1ns / 1ps
// qr_reed_solomon_ecc_encoder_test: stimulus and verdict for the QR parity encoder
// drives data blocks and parity counts, qrrs_parity_checker does the predicting
// depends on qrrs_pkg, qr_reed_solomon_ecc_encoder, qrrs_parity_checker
module qr_reed_solomon_ecc_encoder_test;
  import qrrs_pkg::*;

  // quiet cycles after the last parity byte before touching the count
  localparam int SETTLE_CYCLES = 16;
  // least number of data requests per count setting in the random part
  localparam int HALF_ITEMS    = 12;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_req_t    in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_req_t   out_data;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  // percent of cycles each side holds off
  int send_idle;
  int recv_idle;

  int mismatch_count;
  int parity_left;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  qr_reed_solomon_ecc_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  qrrs_parity_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .parity_left    (parity_left)
  );

  // receiver back-pressure, redrawn every cycle; zero percent gives clean stretches
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // one data request: random idle gap first, then hold until taken
  // returns in the step of acceptance, so the caller drives the next value
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= b;
    in_data.last_data <= last;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // random bytes; close marks the final one as the end of the block
  task automatic send_block(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
    end
  endtask

  // drop valid, let every queued parity byte drain, then let the pipe go quiet
  // the checker's count is registered, so look only after the next edge
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (parity_left != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] count);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // generous fixed limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int sent;
    int len;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    send_idle = 36;
    recv_idle = 55;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, reset count of 7 ---
    // all-zero single byte block
    push_byte(8'h00, 1'b1);
    // all-ones block
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b1);
    // block left open, the count write below must throw the partial remainder away
    push_byte(8'h5A, 1'b0);
    push_byte(8'hC3, 1'b0);
    settle();
    write_count(5'd1);
    // single parity byte
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    settle();
    // zero count behaves as one
    write_count(5'd0);
    push_byte(8'hA5, 1'b1);
    settle();
    // largest count
    write_count(5'd30);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    settle();
    // count above the maximum saturates
    write_count(5'd31);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    settle();
    write_count(5'd2);
    push_byte(8'h3C, 1'b1);

    // --- random part: three idling phases, two counts in each ---
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 36;
          recv_idle = 55;
        end
        1: begin
          send_idle = 55;
          recv_idle = 36;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int h = 0; h < 2; h++) begin
        settle();
        write_count(5'($urandom_range(0, 31)));
        sent = 0;
        while (sent < HALF_ITEMS) begin
          // mostly short blocks, now and then a longer one
          if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(6, 16);
          end else begin
            len = $urandom_range(1, 5);
          end
          send_block(len, 1'b1);
          sent += len;
        end
        // sometimes leave a block unfinished before the next count write
        if ($urandom_range(0, 1) == 1) begin
          send_block($urandom_range(1, 3), 1'b0);
        end
      end
    end

    // drain and give the verdict
    settle();
    if (mismatch_count == 0 && parity_left == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/qrrs_pkg.sv
sv/qrrs_lfsr.sv
sv/qr_reed_solomon_ecc_encoder.sv
tb/qrrs_parity_checker.sv
tb/qr_reed_solomon_ecc_encoder_test.sv
